FILE: src/patterned_line_rasterizer_macros.svh
// ---------------------------------------------------------------------------
// patterned line rasterizer assertion macros
// concurrent checks sampled on clk, switched off while rst is high
// ---------------------------------------------------------------------------
`ifndef PATTERNED_LINE_RASTERIZER_MACROS_SVH
`define PATTERNED_LINE_RASTERIZER_MACROS_SVH

// same-cycle implication
`define PLR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plr check failed");

// next-cycle implication
`define PLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plr check failed");

`endif

FILE: src/plr_pkg.sv
// ---------------------------------------------------------------------------
// plr_pkg
// shared types and constants of the patterned line rasterizer
// ---------------------------------------------------------------------------
package plr_pkg;

  localparam int MASK_BITS      = 16;
  localparam int LEN_BITS       = 5;
  localparam int EFF_LEN_BITS   = 6;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_MASK   = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 1'd1;

  localparam logic [MASK_BITS-1:0] MASK_RESET = 16'hffff;
  localparam logic [LEN_BITS-1:0]  LEN_RESET  = 5'd16;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef struct packed {
    logic [MASK_BITS-1:0]    mask;
    logic [EFF_LEN_BITS-1:0] length;
  } pat_cfg_t;

endpackage

FILE: src/plr_cfg_regs.sv
// ---------------------------------------------------------------------------
// plr_cfg_regs
// style pattern registers, with the period clamped to its legal range
// ---------------------------------------------------------------------------
module plr_cfg_regs #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [plr_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [plr_pkg::MASK_BITS-1:0]      wr_data,
  output plr_pkg::pat_cfg_t                  pat
);
  import plr_pkg::*;

  logic [MASK_BITS-1:0]    pattern_mask;
  logic [LEN_BITS-1:0]     pattern_length;
  logic [EFF_LEN_BITS-1:0] len_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mask   <= MASK_RESET;
      pattern_length <= LEN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_PATTERN_MASK:   pattern_mask   <= wr_data;
        REG_PATTERN_LENGTH: pattern_length <= wr_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // zero means one, above the maximum saturates
  always_comb begin
    len_ext = EFF_LEN_BITS'(pattern_length);
    pat.mask = pattern_mask;
    if (len_ext == '0) begin
      pat.length = EFF_LEN_BITS'(1);
    end else if (len_ext > EFF_LEN_BITS'(PATTERN_MAX)) begin
      pat.length = EFF_LEN_BITS'(PATTERN_MAX);
    end else begin
      pat.length = len_ext;
    end
  end

endmodule

FILE: src/plr_walker.sv
// ---------------------------------------------------------------------------
// plr_walker
// bresenham line state, setup on start and one pixel step per request
// ---------------------------------------------------------------------------
`include "patterned_line_rasterizer_macros.svh"

module plr_walker #(
  parameter int COORD_BITS  = 10,
  parameter int PATTERN_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_en,
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  plr_pkg::pat_cfg_t     pat,
  output logic                  pixel_valid,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  plot,
  output logic                  last
);
  import plr_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 3;
  localparam int POS_BITS = $clog2(PATTERN_MAX);

  logic                       line_active, line_active_next;
  logic [COORD_BITS-1:0]      major_pos, major_pos_next;
  logic [COORD_BITS-1:0]      minor_pos, minor_pos_next;
  logic [COORD_BITS-1:0]      major_span, major_span_next;
  logic [COORD_BITS-1:0]      minor_span, minor_span_next;
  logic                       major_dir_neg, major_dir_neg_next;
  logic                       minor_dir_neg, minor_dir_neg_next;
  logic                       axes_swapped, axes_swapped_next;
  logic signed [ERR_BITS-1:0] error_term, error_term_next;
  logic [COORD_BITS-1:0]      steps_left, steps_left_next;
  logic [POS_BITS-1:0]        pattern_pos, pattern_pos_next;

  logic [COORD_BITS-1:0]      adx, ady;
  logic                       xneg, yneg, swap;
  logic [COORD_BITS-1:0]      s_major, s_minor;
  logic [POS_BITS-1:0]        idx;
  logic [EFF_LEN_BITS-1:0]    idx_ext;
  logic signed [ERR_BITS-1:0] two_minor, two_major;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active   <= 1'b0;
      major_pos     <= '0;
      minor_pos     <= '0;
      major_span    <= '0;
      minor_span    <= '0;
      major_dir_neg <= 1'b0;
      minor_dir_neg <= 1'b0;
      axes_swapped  <= 1'b0;
      error_term    <= '0;
      steps_left    <= '0;
      pattern_pos   <= '0;
    end else if (step_en) begin
      line_active   <= line_active_next;
      major_pos     <= major_pos_next;
      minor_pos     <= minor_pos_next;
      major_span    <= major_span_next;
      minor_span    <= minor_span_next;
      major_dir_neg <= major_dir_neg_next;
      minor_dir_neg <= minor_dir_neg_next;
      axes_swapped  <= axes_swapped_next;
      error_term    <= error_term_next;
      steps_left    <= steps_left_next;
      pattern_pos   <= pattern_pos_next;
    end
  end

  // setup terms
  always_comb begin
    adx     = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
    ady     = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
    xneg    = !(x_end > x_start);
    yneg    = !(y_end > y_start);
    swap    = adx < ady;
    s_major = swap ? ady : adx;
    s_minor = swap ? adx : ady;
  end

  // pattern position, wrapped if the period shrank mid line
  always_comb begin
    idx     = (EFF_LEN_BITS'(pattern_pos) < pat.length) ? pattern_pos : '0;
    idx_ext = EFF_LEN_BITS'(idx);
  end

  always_comb begin
    two_minor = ERR_BITS'({minor_span, 1'b0});
    two_major = ERR_BITS'({major_span, 1'b0});

    line_active_next   = line_active;
    major_pos_next     = major_pos;
    minor_pos_next     = minor_pos;
    major_span_next    = major_span;
    minor_span_next    = minor_span;
    major_dir_neg_next = major_dir_neg;
    minor_dir_neg_next = minor_dir_neg;
    axes_swapped_next  = axes_swapped;
    error_term_next    = error_term;
    steps_left_next    = steps_left;
    pattern_pos_next   = pattern_pos;

    pixel_valid = 1'b0;
    pixel_x     = '0;
    pixel_y     = '0;
    plot        = 1'b0;
    last        = 1'b0;

    if (req_type == REQ_START) begin
      axes_swapped_next  = swap;
      major_pos_next     = swap ? y_start : x_start;
      minor_pos_next     = swap ? x_start : y_start;
      major_span_next    = s_major;
      minor_span_next    = s_minor;
      major_dir_neg_next = swap ? yneg : xneg;
      minor_dir_neg_next = swap ? xneg : yneg;
      error_term_next    = ERR_BITS'({s_minor, 1'b0}) - ERR_BITS'(s_major);
      steps_left_next    = s_major;
      pattern_pos_next   = '0;
      line_active_next   = s_major != '0;
    end else if (line_active) begin
      pixel_valid = 1'b1;
      pixel_x     = axes_swapped ? minor_pos : major_pos;
      pixel_y     = axes_swapped ? major_pos : minor_pos;
      plot        = (idx_ext < EFF_LEN_BITS'(MASK_BITS)) && pat.mask[idx_ext[3:0]];
      last        = steps_left <= COORD_BITS'(1);

      major_pos_next = major_dir_neg ? (major_pos - COORD_BITS'(1))
                                     : (major_pos + COORD_BITS'(1));
      if (error_term[ERR_BITS-1]) begin
        error_term_next = error_term + two_minor;
      end else begin
        minor_pos_next  = minor_dir_neg ? (minor_pos - COORD_BITS'(1))
                                        : (minor_pos + COORD_BITS'(1));
        error_term_next = error_term + two_minor - two_major;
      end
      pattern_pos_next = ((idx_ext + EFF_LEN_BITS'(1)) >= pat.length) ? '0
                                                                      : (idx + POS_BITS'(1));
      steps_left_next  = steps_left - COORD_BITS'(1);
      line_active_next = steps_left != COORD_BITS'(1);
    end
  end

  `PLR_ASSERT_NOW(a_active_has_steps, line_active, steps_left != '0)
  `PLR_ASSERT_NEXT(a_point_line_idle,
    step_en && req_type == REQ_START && x_start == x_end && y_start == y_end, !line_active)
  `PLR_ASSERT_NOW(a_idle_step_empty,
    step_en && req_type == REQ_STEP && !line_active, !pixel_valid && !last)
  `PLR_ASSERT_NEXT(a_last_ends_line,
    step_en && req_type == REQ_STEP && line_active && last, !line_active)

endmodule

FILE: src/patterned_line_rasterizer.sv
// ---------------------------------------------------------------------------
// patterned_line_rasterizer
// bresenham line walker with a configurable dash pattern
// ---------------------------------------------------------------------------
// One request is taken per clock unless m_axis_tready holds the pipe, and is
// answered by exactly one result, one pixel a cycle at full rate. A request
// is held in the input register, the line step is worked out in the walker
// and lands in the result register; s_axis_tready follows m_axis_tready
// combinationally through those two registers. A start request answers with
// tuser low and zero data; a step answers with the next pixel of the active
// line, or tuser low once the line is finished. Write the pattern registers
// only while no request is in flight.
module patterned_line_rasterizer #(
  parameter int COORD_BITS  = 10,
  parameter int PATTERN_MAX = 16
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              s_axis_tvalid,
  output logic                                              s_axis_tready,
  // x_start, y_start, x_end, y_end, zero padding
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]                 s_axis_tdata,
  // req_type
  input  logic                                              s_axis_tuser,
  output logic                                              m_axis_tvalid,
  input  logic                                              m_axis_tready,
  // pixel_x, pixel_y, plot, zero padding
  output logic [((2*COORD_BITS+8)/8)*8-1:0]                 m_axis_tdata,
  // pixel_valid
  output logic                                              m_axis_tuser,
  output logic                                              m_axis_tlast,
  input  logic                                              cfg_valid,
  output logic                                              cfg_ready,
  input  logic [plr_pkg::CFG_INDEX_BITS-1:0]                cfg_index,
  input  logic [plr_pkg::MASK_BITS-1:0]                     cfg_data
);
  import plr_pkg::*;

  localparam int OUT_BITS = 2*COORD_BITS + 1;
  localparam int OUT_W    = ((2*COORD_BITS+8)/8)*8;

  pat_cfg_t pat;

  logic                  in_valid;
  logic                  in_req_type;
  logic [COORD_BITS-1:0] in_x_start, in_y_start, in_x_end, in_y_end;
  logic                  advance;
  logic                  s_fire;

  logic                  w_pixel_valid, w_plot, w_last;
  logic [COORD_BITS-1:0] w_pixel_x, w_pixel_y;

  logic                  out_valid;
  logic                  out_pixel_valid, out_plot, out_last;
  logic [COORD_BITS-1:0] out_pixel_x, out_pixel_y;

  assign cfg_ready     = 1'b1;
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  plr_cfg_regs #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .pat      (pat)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_req_type <= s_axis_tuser;
      in_x_start  <= s_axis_tdata[0*COORD_BITS +: COORD_BITS];
      in_y_start  <= s_axis_tdata[1*COORD_BITS +: COORD_BITS];
      in_x_end    <= s_axis_tdata[2*COORD_BITS +: COORD_BITS];
      in_y_end    <= s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    end
  end

  plr_walker #(
    .COORD_BITS  (COORD_BITS),
    .PATTERN_MAX (PATTERN_MAX)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .step_en     (in_valid && advance),
    .req_type    (in_req_type),
    .x_start     (in_x_start),
    .y_start     (in_y_start),
    .x_end       (in_x_end),
    .y_end       (in_y_end),
    .pat         (pat),
    .pixel_valid (w_pixel_valid),
    .pixel_x     (w_pixel_x),
    .pixel_y     (w_pixel_y),
    .plot        (w_plot),
    .last        (w_last)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_pixel_valid <= w_pixel_valid;
      out_pixel_x     <= w_pixel_x;
      out_pixel_y     <= w_pixel_y;
      out_plot        <= w_plot;
      out_last        <= w_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_pixel_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = OUT_W'({out_plot, out_pixel_y, out_pixel_x});

  // width of the zero padding above the packed result
  localparam int PAD_BITS = OUT_W - OUT_BITS;
  if (PAD_BITS < 0) begin : g_bad_width
    $error("result does not fit tdata");
  end

endmodule

FILE: tb/sv/plr_pixel_checker.sv
// ---------------------------------------------------------------------------
// plr_pixel_checker
// watches the request, result and register channels of the rasterizer,
// walks each line alongside the block and compares every result transfer
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module plr_pixel_checker #(
  parameter int COORD_BITS = 10,
  parameter int IN_W       = ((4*COORD_BITS+7)/8)*8,
  parameter int OUT_W      = ((2*COORD_BITS+8)/8)*8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [IN_W-1:0]                    s_axis_tdata,
  input  logic                               s_axis_tuser,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [OUT_W-1:0]                   m_axis_tdata,
  input  logic                               m_axis_tuser,
  input  logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [plr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [plr_pkg::MASK_BITS-1:0]      cfg_data,
  output int                                 pending,
  output int                                 failures
);
  import plr_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    logic   plot;
    logic   last;
  } pixel_t;

  pixel_t due_pixels[$];

  logic [MASK_BITS-1:0] style_mask;
  logic [LEN_BITS-1:0]  style_len;

  logic               active;
  coord_t             maj_pos, min_pos, maj_span, min_span, steps_left;
  logic               maj_neg, min_neg, swapped;
  logic signed [12:0] err;
  logic [3:0]         pat_pos;

  function automatic coord_t step_coord(input coord_t p, input logic neg);
    return neg ? p - coord_t'(1) : p + coord_t'(1);
  endfunction

  // advance the line walker by one request and return the pixel it yields
  function automatic pixel_t walk_line(input logic req, input logic [IN_W-1:0] d);
    pixel_t px;
    coord_t xs, ys, xe, ye, adx, ady;
    logic   xneg, yneg;
    int     len;
    logic [3:0] idx;
    px = '0;
    if (req == REQ_START) begin
      xs = d[COORD_BITS-1:0];
      ys = d[2*COORD_BITS-1:COORD_BITS];
      xe = d[3*COORD_BITS-1:2*COORD_BITS];
      ye = d[4*COORD_BITS-1:3*COORD_BITS];
      adx = (xe > xs) ? xe - xs : xs - xe;
      ady = (ye > ys) ? ye - ys : ys - ye;
      xneg = !(xe > xs);
      yneg = !(ye > ys);
      if (adx < ady) begin
        swapped = 1'b1;
        maj_pos = ys; min_pos = xs; maj_span = ady; min_span = adx;
        maj_neg = yneg; min_neg = xneg;
      end else begin
        swapped = 1'b0;
        maj_pos = xs; min_pos = ys; maj_span = adx; min_span = ady;
        maj_neg = xneg; min_neg = yneg;
      end
      err = 13'(2*int'(min_span) - int'(maj_span));
      steps_left = maj_span;
      pat_pos = '0;
      active = (maj_span != '0);
    end else if (active) begin
      len = (style_len == '0) ? 1 : ((int'(style_len) > 16) ? 16 : int'(style_len));
      idx = (int'(pat_pos) < len) ? pat_pos : 4'd0;
      px.valid = 1'b1;
      px.plot  = style_mask[idx];
      px.last  = (steps_left <= coord_t'(1));
      px.x     = swapped ? min_pos : maj_pos;
      px.y     = swapped ? maj_pos : min_pos;
      maj_pos = step_coord(maj_pos, maj_neg);
      if (err < 0) begin
        err = 13'(int'(err) + 2*int'(min_span));
      end else begin
        min_pos = step_coord(min_pos, min_neg);
        err = 13'(int'(err) + 2*int'(min_span) - 2*int'(maj_span));
      end
      pat_pos = (int'(idx) + 1 >= len) ? 4'd0 : idx + 4'd1;
      if (steps_left != '0) steps_left = steps_left - coord_t'(1);
      if (steps_left == '0) active = 1'b0;
    end
    return px;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      due_pixels.delete();
      failures = 0;
      style_mask = MASK_RESET;
      style_len  = LEN_RESET;
      active = 1'b0;
      maj_pos = '0; min_pos = '0; maj_span = '0; min_span = '0; steps_left = '0;
      maj_neg = 1'b0; min_neg = 1'b0; swapped = 1'b0;
      err = '0;
      pat_pos = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PATTERN_MASK) style_mask = cfg_data;
        else if (cfg_index == REG_PATTERN_LENGTH) style_len = cfg_data[LEN_BITS-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_pixels.size() == 0) begin
          $error("result transfer with no request outstanding");
          failures++;
        end else begin
          want = due_pixels.pop_front();
          check_field("pixel_valid", int'(want.valid), int'(m_axis_tuser));
          check_field("pixel_x", int'(want.x), int'(m_axis_tdata[COORD_BITS-1:0]));
          check_field("pixel_y", int'(want.y),
                      int'(m_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
          check_field("plot", int'(want.plot), int'(m_axis_tdata[2*COORD_BITS]));
          check_field("last", int'(want.last), int'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        due_pixels.push_back(walk_line(s_axis_tuser, s_axis_tdata));
    end
    pending = due_pixels.size();
  end

endmodule

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// drives line and step requests and pattern settings into the rasterizer
// under changing back-pressure; a checker beside the block predicts pixels
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import plr_pkg::*;

  localparam int COORD_BITS = 10;
  localparam int IN_W       = ((4*COORD_BITS+7)/8)*8;
  localparam int OUT_W      = ((2*COORD_BITS+8)/8)*8;
  localparam int CMAX       = (1 << COORD_BITS) - 1;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_W-1:0]           s_axis_tdata = '0;
  logic                      s_axis_tuser = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_W-1:0]          m_axis_tdata;
  logic                      m_axis_tuser;
  logic                      m_axis_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [MASK_BITS-1:0]      cfg_data = '0;

  int pending;
  int failures;
  int send_gap_pct = 9;
  int take_gap_pct = 54;
  int req_count    = 0;
  int line_count   = 0;
  int style_count  = 0;

  patterned_line_rasterizer #(.COORD_BITS(COORD_BITS), .PATTERN_MAX(16)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  plr_pixel_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .failures(failures)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
  end

  // entered and left at a falling edge
  task automatic send_req(input logic req, input logic [COORD_BITS-1:0] xs,
                          input logic [COORD_BITS-1:0] ys, input logic [COORD_BITS-1:0] xe,
                          input logic [COORD_BITS-1:0] ye);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= IN_W'({ye, xe, ys, xs});
    do @(posedge clk); while (!s_axis_tready);
    req_count++;
    @(negedge clk);
  endtask

  task automatic start_line(input int xs, input int ys, input int xe, input int ye);
    send_req(REQ_START, COORD_BITS'(xs), COORD_BITS'(ys), COORD_BITS'(xe),
             COORD_BITS'(ye));
    line_count++;
  endtask

  task automatic step_n(input int n);
    repeat (n)
      send_req(REQ_STEP, COORD_BITS'($urandom_range(CMAX)),
               COORD_BITS'($urandom_range(CMAX)), COORD_BITS'($urandom_range(CMAX)),
               COORD_BITS'($urandom_range(CMAX)));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [MASK_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // upper bits of the length transfer carry noise
  task automatic set_style(input logic [MASK_BITS-1:0] mask, input int len);
    drain();
    write_reg(REG_PATTERN_MASK, mask);
    write_reg(REG_PATTERN_LENGTH, {MASK_BITS'($urandom_range(2047)) << LEN_BITS} |
                                  MASK_BITS'(len));
    style_count++;
  endtask

  function automatic int near_coord(input int c);
    int v;
    v = c + int'($urandom_range(24)) - 12;
    if (v < 0) v = 0;
    if (v > CMAX) v = CMAX;
    return v;
  endfunction

  task automatic random_line();
    int xs, ys, xe, ye, span, n, r;
    r = $urandom_range(99);
    if (r < 8) begin
      xs = $urandom_range(CMAX); ys = $urandom_range(CMAX);
      xe = $urandom_range(CMAX); ye = $urandom_range(CMAX);
    end else if (r < 14) begin
      xs = $urandom_range(1) ? CMAX : 0; ys = $urandom_range(1) ? CMAX : 0;
      xe = $urandom_range(1) ? CMAX : 0; ye = $urandom_range(1) ? CMAX : 0;
    end else begin
      xs = $urandom_range(CMAX); ys = $urandom_range(CMAX);
      xe = near_coord(xs); ye = near_coord(ys);
    end
    start_line(xs, ys, xe, ye);
    span = (xe > xs) ? xe - xs : xs - xe;
    if (((ye > ys) ? ye - ys : ys - ye) > span) span = (ye > ys) ? ye - ys : ys - ye;
    r = $urandom_range(99);
    if (r < 70) n = span;
    else if (r < 85) n = span + int'($urandom_range(1, 3));
    else n = $urandom_range(span);
    if (n > 40 && $urandom_range(9) != 0) n = $urandom_range(1, 40);
    step_n(n);
  endtask

  task automatic random_burst();
    int c;
    if ($urandom_range(99) < 10) begin
      if ($urandom_range(1)) begin
        step_n(1);
      end else begin
        c = $urandom_range(CMAX);
        start_line(c, c ^ 1, c, c ^ 1);
      end
    end else begin
      random_line();
    end
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle steps, zero-length line, both axes, both directions
    step_n(1);
    start_line(0, 0, 0, 0);
    step_n(1);
    start_line(0, 0, 3, 1);
    step_n(4);
    start_line(CMAX, CMAX, CMAX - 3, CMAX - 1);
    step_n(2);
    start_line(5, 5, 6, 9);
    step_n(2);
    start_line(10, 10, 13, 7);
    step_n(3);
    set_style(16'h005f, 16);
    start_line(0, CMAX, 8, CMAX - 3);
    step_n(6);
    // shorten the pattern while the line is still being walked
    drain();
    write_reg(REG_PATTERN_LENGTH, 16'd4);
    step_n(2);
    set_style(16'h0000, 0);
    start_line(CMAX, 0, 0, 2);
    step_n(3);

    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct = (mode == 0) ? 9 : ((mode == 1) ? 54 : 0);
      take_gap_pct = (mode == 0) ? 54 : ((mode == 1) ? 9 : 0);
      for (int s = 0; s < 3; s++) begin
        case ((mode * 3 + s) % 9)
          0: set_style(16'hffff, 16);
          1: set_style(16'h0001, 2);
          2: set_style(16'h03fc, 10);
          3: set_style(16'h005f, 16);
          4: set_style(16'h0000, 1);
          5: set_style(MASK_BITS'($urandom), 31);
          6: set_style(MASK_BITS'($urandom), 0);
          7: set_style(MASK_BITS'($urandom), 17);
          default: set_style(MASK_BITS'($urandom), $urandom_range(31));
        endcase
        target = req_count + 65;
        while (req_count < target) random_burst();
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("covered %0d requests over %0d lines under %0d pattern settings,",
             req_count, line_count, style_count);
    $display("with sender and receiver stalls swapped and then removed");
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
